/* rtl/window_iqr_outlier_mean_assert.svh */
// Assertion macros shared by the window outlier-mean RTL.
`ifndef WINDOW_IQR_OUTLIER_MEAN_ASSERT_SVH
`define WINDOW_IQR_OUTLIER_MEAN_ASSERT_SVH
`ifndef SYNTHESIS
`define WIOM_ASSERT_IMPL(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define WIOM_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition");
`else
`define WIOM_ASSERT_IMPL(label, clk, rstn, prop)
`define WIOM_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

/* rtl/wiom_pkg.sv */
package wiom_pkg;
  localparam int unsigned DataW = 24;
  localparam int unsigned DefWindowLen = 30;
  localparam int unsigned DefStep = 5;
  localparam int unsigned DefQ1Pos = 6;
  localparam int unsigned DefQ3Pos = 22;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DRAIN,
    ST_SORT,
    ST_QUART,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } wiom_state_e;
endpackage

/* rtl/wiom_cell.sv */
// One sorting cell: keeps the larger of its stored value and the value
// arriving from the left neighbor, and passes the smaller one to the right
// through a register, so a value moves one cell per cycle.
// Once the row is loaded, a shift mode moves all values one cell rightward.
module wiom_cell import wiom_pkg::*; (
  input  logic                    clk_i,
  input  logic                    clear_i,
  input  logic                    ins_i,
  input  logic                    shift_i,
  input  logic signed [DataW-1:0] left_i,
  input  logic                    left_vld_i,
  output logic signed [DataW-1:0] pass_o,
  output logic                    pass_vld_o,
  input  logic                    rst_ni
);
  logic signed [DataW-1:0] val_q, val_d;
  logic                    vld_q, vld_d;
  logic signed [DataW-1:0] pass_q, pass_d;
  logic                    pass_vld_q, pass_vld_d;

  always_comb begin
    val_d      = val_q;
    vld_d      = vld_q;
    pass_d     = left_i;
    pass_vld_d = 1'b0;
    if (clear_i) begin
      vld_d = 1'b0;
    end else if (shift_i) begin
      val_d = left_i;
      vld_d = left_vld_i;
    end else if (ins_i && left_vld_i) begin
      if (!vld_q) begin
        val_d = left_i;
        vld_d = 1'b1;
      end else begin
        pass_vld_d = 1'b1;
        if (left_i > val_q) begin
          val_d  = left_i;
          pass_d = val_q;
        end
      end
    end
  end

  // In shift mode the stored value goes straight to the neighbor.
  assign pass_o     = shift_i ? val_q : pass_q;
  assign pass_vld_o = shift_i ? vld_q : pass_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= 1'b0;
      pass_vld_q <= 1'b0;
    end else begin
      vld_q      <= vld_d;
      pass_vld_q <= pass_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pass_q <= pass_d;
  end
endmodule

/* rtl/wiom_div.sv */
// Restoring divider for signed sum over unsigned count, truncating to zero.
module wiom_div import wiom_pkg::*; #(
  parameter int unsigned SumW = 31,
  parameter int unsigned CntW = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] sum_i,
  input  logic [CntW-1:0]        cnt_i,
  output logic                   done_o,
  output logic signed [DataW-1:0] quot_o
);
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]  num_q, num_d;
  logic [CntW:0]    rem_q, rem_d;
  logic [CntW-1:0]  den_q, den_d;
  logic             neg_q, neg_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [CntW:0]    trial;
  logic [SumW-1:0]  mag;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    mag    = sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);
    trial  = {rem_q[CntW-1:0], num_q[SumW-1]};
    if (start_i) begin
      num_d  = mag;
      rem_d  = '0;
      den_d  = cnt_i;
      neg_d  = sum_i[SumW-1];
      cnt_d  = StepW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          num_d = {num_q[SumW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          num_d = {num_q[SumW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
    quot_o = neg_q ? DataW'(-num_q) : DataW'(num_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end
endmodule

/* rtl/window_iqr_outlier_mean.sv */
// Sliding-window mean with interquartile outlier rejection. Each accepted
// transaction carries one signed Q8.16 sample that is written into a ring of
// WINDOW_LEN entries. On every STEP-th transaction, once the ring has filled,
// the block sorts the window, picks Q1 and Q3 at fixed sorted positions, keeps
// the samples inside [Q1-1.5*IQR, Q3+1.5*IQR], and emits their mean truncated
// toward zero; other transactions produce no result. The window is sorted by a
// row of WINDOW_LEN insertion cells with a register between neighbors: the
// ring is read one entry per cycle into the row, the last values ripple to
// their cells, the row shifts out one value per cycle for the quartile
// capture, the fences are computed, the ring is read again for the sum, a
// restoring divider works through the sum one bit at a time, and the mean is
// handed to the output register. A triggering transaction therefore holds
// input stall high through all of these steps, and longer while the previous
// mean still waits in the output register. Any other transaction is accepted
// even while a mean waits to be taken.
module window_iqr_outlier_mean import wiom_pkg::*; #(
  parameter int unsigned WINDOW_LEN = DefWindowLen,
  parameter int unsigned STEP       = DefStep,
  parameter int unsigned Q1_POS     = DefQ1Pos,
  parameter int unsigned Q3_POS     = DefQ3Pos
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    sample_valid_i,
  output logic                    sample_stall_o,
  input  logic signed [DataW-1:0] sample_i,
  output logic                    average_valid_o,
  input  logic                    average_stall_i,
  output logic signed [DataW-1:0] average_o
);
`include "window_iqr_outlier_mean_assert.svh"

  localparam int unsigned PosW  = $clog2(WINDOW_LEN);
  localparam int unsigned CntW  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned StepW = (STEP > 1) ? $clog2(STEP) : 1;
  localparam int unsigned SumW  = DataW + CntW;
  localparam int unsigned WideW = DataW + 5;
  localparam int unsigned Q1C   = (Q1_POS > WINDOW_LEN - 1) ? WINDOW_LEN - 1 : Q1_POS;
  localparam int unsigned Q3C   = (Q3_POS > WINDOW_LEN - 1) ? WINDOW_LEN - 1 : Q3_POS;

  // Ring memory; entries are read only after a full lap has written them all.
  logic signed [DataW-1:0] ring_mem [WINDOW_LEN];
  logic signed [DataW-1:0] rd_data_q;

  logic [PosW-1:0]  wr_pos_q, wr_pos_d;
  logic [StepW-1:0] step_q, step_d;
  logic             filled_q, filled_d;
  wiom_state_e      state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic [PosW-1:0]  rd_pos_q, rd_pos_d;
  logic signed [DataW-1:0] q1_q, q1_d, q3_q, q3_d;
  logic signed [WideW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]         kept_q, kept_d;
  logic signed [DataW-1:0] avg_q, avg_d;
  logic                    out_vld_q, out_vld_d;
  logic                    in_acc, trig;
  logic                    clr, ins, shf, div_start, div_done;
  logic signed [DataW-1:0] div_q;

  logic signed [DataW-1:0] chain_val [WINDOW_LEN+1];
  logic                    chain_vld [WINDOW_LEN+1];

  // Input is taken only while no window is in progress; a waiting mean sits
  // in its own register and does not hold the input back.
  assign sample_stall_o = (state_q != ST_IDLE);

  assign in_acc = sample_valid_i && !sample_stall_o;
  assign trig   = in_acc && (step_q == StepW'(STEP - 1)) &&
                  (filled_q || (wr_pos_q == PosW'(WINDOW_LEN - 1)));

  assign chain_val[0] = rd_data_q;
  assign chain_vld[0] = rd_vld_q;

  for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_row
    wiom_cell u_cell (
      .clk_i      (clk_i),
      .clear_i    (clr),
      .ins_i      (ins),
      .shift_i    (shf),
      .left_i     (chain_val[g]),
      .left_vld_i (chain_vld[g]),
      .pass_o     (chain_val[g+1]),
      .pass_vld_o (chain_vld[g+1]),
      .rst_ni     (rst_ni)
    );
  end

  // The row holds descending values from cell 0; shifting out the last cell
  // yields ascending order.

  wiom_div #(.SumW(SumW), .CntW(CntW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_q),
    .cnt_i   (kept_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  always_comb begin
    wr_pos_d       = wr_pos_q;
    step_d         = step_q;
    filled_d       = filled_q;
    state_d        = state_q;
    idx_d          = idx_q;
    rd_vld_d       = 1'b0;
    rd_pos_d       = rd_pos_q;
    q1_d           = q1_q;
    q3_d           = q3_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    sum_d          = sum_q;
    kept_d         = kept_q;
    avg_d          = avg_q;
    out_vld_d      = out_vld_q;
    clr            = 1'b0;
    ins            = 1'b0;
    shf            = 1'b0;
    div_start      = 1'b0;

    if (out_vld_q && !average_stall_i) begin
      out_vld_d = 1'b0;
    end

    if (in_acc) begin
      wr_pos_d = (wr_pos_q == PosW'(WINDOW_LEN - 1)) ? '0 : wr_pos_q + 1'b1;
      if (wr_pos_q == PosW'(WINDOW_LEN - 1)) begin
        filled_d = 1'b1;
      end
      step_d = (step_q == StepW'(STEP - 1)) ? '0 : step_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (trig) begin
          state_d  = ST_LOAD;
          clr      = 1'b1;
          idx_d    = '0;
          rd_pos_d = '0;
        end
      end
      ST_LOAD: begin
        ins = 1'b1;
        if (idx_q < CntW'(WINDOW_LEN)) begin
          rd_vld_d = 1'b1;
          rd_pos_d = (rd_pos_q == PosW'(WINDOW_LEN - 1)) ? '0 : rd_pos_q + 1'b1;
          idx_d    = idx_q + 1'b1;
        end else begin
          // Last read value enters the row this cycle.
          state_d = ST_DRAIN;
          idx_d   = '0;
        end
      end
      ST_DRAIN: begin
        // Displaced values still travel one cell per cycle until every cell
        // holds its final value.
        ins   = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == CntW'(WINDOW_LEN - 1)) begin
          state_d = ST_QUART;
          idx_d   = '0;
        end
      end
      ST_QUART: begin
        shf = 1'b1;
        rd_vld_d = 1'b0;
        if (idx_q == CntW'(Q1C)) begin
          q1_d = chain_val[WINDOW_LEN];
        end
        if (idx_q == CntW'(Q3C)) begin
          q3_d = chain_val[WINDOW_LEN];
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == CntW'(WINDOW_LEN - 1)) begin
          state_d = ST_SORT;
          idx_d   = '0;
        end
      end
      ST_SORT: begin
        // Bounds at doubled scale: 5*q1-3*q3 and 5*q3-3*q1.
        lo_d     = (WideW'(q1_q) <<< 2) + WideW'(q1_q)
                   - (WideW'(q3_q) <<< 1) - WideW'(q3_q);
        hi_d     = (WideW'(q3_q) <<< 2) + WideW'(q3_q)
                   - (WideW'(q1_q) <<< 1) - WideW'(q1_q);
        sum_d    = '0;
        kept_d   = '0;
        clr      = 1'b1;
        idx_d    = '0;
        rd_pos_d = '0;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        // The order of summing does not matter, so samples are taken
        // straight from the memory read port.
        if (idx_q < CntW'(WINDOW_LEN)) begin
          rd_vld_d = 1'b1;
          rd_pos_d = (rd_pos_q == PosW'(WINDOW_LEN - 1)) ? '0 : rd_pos_q + 1'b1;
          idx_d    = idx_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (((WideW'(rd_data_q) <<< 1) >= lo_q) &&
              ((WideW'(rd_data_q) <<< 1) <= hi_q)) begin
            sum_d  = sum_q + SumW'(rd_data_q);
            kept_d = kept_q + 1'b1;
          end
        end
        if (!rd_vld_q && (idx_q == CntW'(WINDOW_LEN))) begin
          if (kept_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // The divider holds its quotient until the output register is free.
        if (!out_vld_q || !average_stall_i) begin
          avg_d     = div_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_mem[wr_pos_q] <= sample_i;
    end
    rd_data_q <= ring_mem[rd_pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q  <= '0;
      step_q    <= '0;
      filled_q  <= 1'b0;
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_pos_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      wr_pos_q  <= wr_pos_d;
      step_q    <= step_d;
      filled_q  <= filled_d;
      state_q   <= state_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      rd_pos_q  <= rd_pos_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q   <= q1_d;
    q3_q   <= q3_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    sum_q  <= sum_d;
    kept_q <= kept_d;
    avg_q  <= avg_d;
  end

  assign average_valid_o = out_vld_q;
  assign average_o       = avg_q;

  // While the sorted row is shifted out, every value leaving it is valid.
  `WIOM_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni,
    (state_q != ST_IDLE) |-> !in_acc)
  `WIOM_ASSERT_IMPL(a_out_held, clk_i, rst_ni,
    (out_vld_q && average_stall_i) |=> (out_vld_q && $stable(avg_q)))
  `WIOM_ASSERT_NEVER(a_kept_range, clk_i, rst_ni,
    (state_q == ST_SUM) && (kept_q > CntW'(WINDOW_LEN)))
  `WIOM_ASSERT_NEVER(a_row_full, clk_i, rst_ni,
    (state_q == ST_QUART) && !chain_vld[WINDOW_LEN])
endmodule

/* tb/window_iqr_outlier_mean_test.sv */
module window_iqr_outlier_mean_test import wiom_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WinLen  = DefWindowLen;
  localparam int unsigned StepLen = DefStep;
  localparam int unsigned Q1Sel   = (DefQ1Pos > WinLen - 1) ? WinLen - 1 : DefQ1Pos;
  localparam int unsigned Q3Sel   = (DefQ3Pos > WinLen - 1) ? WinLen - 1 : DefQ3Pos;
  localparam int unsigned NumRandom = 1350;

  // Predicts the outlier-rejected window mean and holds the averages that are
  // still owed by the block, oldest first.
  class mean_scoreboard;
    logic signed [DataW-1:0] ring[WinLen];
    int unsigned             wr_pos;
    int unsigned             phase;
    bit                      full;
    logic signed [DataW-1:0] pending_avg[$];
    int unsigned             errors;

    function new();
      wr_pos = 0;
      phase = 0;
      full = 0;
      errors = 0;
      foreach (ring[k]) ring[k] = '0;
    endfunction

    // Notes one accepted sample and queues the average it triggers, if any.
    function void note_sample(logic signed [DataW-1:0] s);
      longint srt[WinLen];
      longint q1, q3, lo2, hi2, acc, cnt, key;
      int     j;
      ring[wr_pos] = s;
      wr_pos++;
      if (wr_pos == WinLen) begin
        wr_pos = 0;
        full = 1;
      end
      phase = (phase + 1) % StepLen;
      if (phase != 0 || !full) return;
      foreach (ring[k]) srt[k] = ring[k];
      for (int i = 1; i < WinLen; i++) begin
        key = srt[i];
        j = i;
        while (j > 0 && srt[j-1] > key) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = key;
      end
      q1 = srt[Q1Sel];
      q3 = srt[Q3Sel];
      lo2 = 5 * q1 - 3 * q3;
      hi2 = 5 * q3 - 3 * q1;
      acc = 0;
      cnt = 0;
      foreach (srt[k]) begin
        if (2 * srt[k] >= lo2 && 2 * srt[k] <= hi2) begin
          acc += srt[k];
          cnt++;
        end
      end
      // SystemVerilog division truncates toward zero, as required.
      if (cnt != 0) pending_avg.push_back(DataW'(acc / cnt));
    endfunction

    function void check_average(logic signed [DataW-1:0] got);
      logic signed [DataW-1:0] want;
      if (pending_avg.size() == 0) begin
        $display("%0t: unexpected average, expected none, actual %0d", $realtime, got);
        errors++;
        return;
      end
      want = pending_avg.pop_front();
      if (got !== want) begin
        $display("%0t: average mismatch, expected %0d, actual %0d", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    sample_valid_i = 1'b0;
  logic                    sample_stall_o;
  logic signed [DataW-1:0] sample_i = '0;
  logic                    average_valid_o;
  logic                    average_stall_i = 1'b0;
  logic signed [DataW-1:0] average_o;

  mean_scoreboard sb = new();
  bit             driving_done = 1'b0;
  bit             hold_off_active = 1'b0;
  int unsigned    averages_seen = 0;

  window_iqr_outlier_mean uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .sample_valid_i(sample_valid_i),
    .sample_stall_o(sample_stall_o),
    .sample_i(sample_i),
    .average_valid_o(average_valid_o),
    .average_stall_i(average_stall_i),
    .average_o(average_o)
  );

  always #5 clk_i = ~clk_i;

  // Offers one sample at the falling edge and holds it until a rising edge
  // accepts the transaction. The scoreboard learns of it at that edge.
  task automatic send_sample(logic signed [DataW-1:0] s);
    sample_i <= s;
    sample_valid_i <= 1'b1;
    do @(posedge clk_i); while (sample_stall_o);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  // Inserts an idle gap of the given length; the valid is dropped only here and
  // at the end of the stimulus, so a back-to-back burst never toggles it within one time step.
  task automatic idle_gap(int unsigned n);
    if (n == 0) return;
    sample_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Random samples are mostly clustered around a center with a sprinkling of
  // wild outliers, so the quartile fence actually rejects something. Some
  // are full-range values, which also reach every bit of the field.
  function automatic logic signed [DataW-1:0] pick_sample(int center);
    int unsigned sel;
    int          v;
    sel = $urandom_range(99);
    if (sel < 15) return DataW'($urandom);
    if (sel < 20) return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
    v = center + $signed($urandom_range(4000)) - 2000;
    return DataW'(v);
  endfunction

  task automatic send_random_burst(ref int unsigned left, input int center);
    int unsigned burst;
    burst = $urandom_range(1, 20);
    while (burst > 0 && left > 0) begin
      send_sample(pick_sample(center));
      burst--;
      left--;
    end
    // Stretches with no gap at all are common.
    if ($urandom_range(2) != 0) idle_gap($urandom_range(1, 12));
  endtask

  // Receiver: stalls on its own pattern, with quiet stretches, and once holds
  // off for a long stretch while the sender keeps offering samples.
  initial begin : receiver
    int unsigned mode;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_active) begin
        average_stall_i <= 1'b1;
      end else begin
        mode = $urandom_range(99);
        average_stall_i <= (mode < 30);
      end
    end
  end

  initial begin : hold_off
    @(posedge rst_ni);
    repeat (3000) @(posedge clk_i);
    hold_off_active = 1'b1;
    repeat (1500) @(posedge clk_i);
    hold_off_active = 1'b0;
  end

  // Results are sampled at the rising edge at which they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && average_valid_o && !average_stall_i) begin
      sb.check_average(average_o);
      averages_seen++;
    end
  end

  initial begin : stimulus
    int unsigned left;
    int          center;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. The first window fills with both extremes and a zero:
    // no average before the window is full, even on step.
    for (int i = 0; i < 10; i++) send_sample(24'sh7fffff);
    for (int i = 0; i < 10; i++) send_sample(24'sh800000);
    send_sample(24'sh000000);
    send_sample(24'sh000001);
    send_sample(-24'sd1);
    send_sample(24'sh555555);
    send_sample(24'shaaaaaa);
    idle_gap(3);

    // Random part: a few full windows of each cluster center, with noise.
    left = NumRandom;
    center = 0;
    while (left > 0) begin
      if ($urandom_range(40) == 0) center = $signed($urandom_range(16000000)) - 8000000;
      send_random_burst(left, center);
    end
    sample_valid_i <= 1'b0;
    driving_done = 1'b1;
  end

  initial begin : finish_run
    wait (driving_done);
    while (sb.pending_avg.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_avg.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Slowest case: about 270 triggering samples, each holding the input through a
  // whole window computation, stalls and gaps on top; this bound is several times that.
  initial begin : watchdog
    #3ms;
    $display("FAILURE");
    $finish;
  end
endmodule
